@@ design/rmth_pkg.sv @@
package rmth_pkg;

    localparam int SAMPLE_W       = 32;
    localparam int MED_W          = 33;
    localparam int SCNT_W         = 11;
    localparam int HEAP_DEPTH_DEF = 512;

    // datapath operations, one per controller step
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_POP_START,
        OP_POP_LAST,
        OP_POP_CHK,
        OP_POP_RC1,
        OP_POP_CMP,
        OP_POP_END,
        OP_PUSH_START,
        OP_PUSH_CHK,
        OP_PUSH_CMP,
        OP_PUSH_END,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic sel_lower;
        logic push_k;
        logic drop;
    } t_dp_cmd;

    typedef struct packed {
        logic l_empty;
        logic u_empty;
        logic full;
        logic v_lt_ltop;
        logic v_gt_utop;
        logic cnt_eq;
        logic push_at_root;
        logic push_rise;
        logic pop_leaf;
        logic pop_sink;
        logic out_free;
    } t_dp_stat;

    // a sits above b: max heap when is_max, else min heap
    function automatic logic above(input logic signed [SAMPLE_W-1:0] a,
                                   input logic signed [SAMPLE_W-1:0] b,
                                   input logic is_max);
        return is_max ? (a > b) : (a < b);
    endfunction

endpackage

@@ design/rmth_ram.sv @@
module rmth_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/rmth_datapath.sv @@
module rmth_datapath import rmth_pkg::*; #(
    parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dp_cmd                    i_cmd,
    output t_dp_stat                   o_stat,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic signed [MED_W-1:0]    o_median_x2,
    output logic [SCNT_W-1:0]          o_sample_count,
    output logic                       o_dropped
);

    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int XW = AW + 2;

    logic [AW-1:0]               r_idx;
    logic [CW-1:0]               r_lcnt, r_ucnt, r_n;
    logic                        r_sel;
    logic signed [SAMPLE_W-1:0]  r_sample, r_val, r_k, r_a, r_ltop, r_utop;
    logic                        r_out_valid, r_drop;
    logic signed [MED_W-1:0]     r_med;
    logic [SCNT_W-1:0]           r_scnt;

    logic [CW-1:0]               sel_cnt;
    logic [XW-1:0]               c1, c2, nx;
    logic [AW-1:0]               parent, cidx, raddr;
    logic signed [SAMPLE_W-1:0]  l_rdata, u_rdata, rdata, chosen, wdata;
    logic                        pick1, sink, rise, we;
    logic signed [MED_W-1:0]     median;
    logic [CW:0]                 cnt_sum;

    assign sel_cnt = i_cmd.sel_lower ? r_lcnt : r_ucnt;
    assign c1      = {1'b0, r_idx, 1'b1};
    assign c2      = c1 + XW'(1);
    assign nx      = XW'(r_n);
    assign parent  = (r_idx - AW'(1)) >> 1;
    assign rdata   = r_sel ? l_rdata : u_rdata;
    assign pick1   = (c2 < nx) && above(rdata, r_a, r_sel);
    assign chosen  = pick1 ? rdata : r_a;
    assign cidx    = pick1 ? c2[AW-1:0] : c1[AW-1:0];
    assign sink    = above(chosen, r_val, r_sel);
    assign rise    = above(r_val, rdata, r_sel);

    always_comb begin
        we    = 1'b0;
        wdata = r_val;
        raddr = '0;
        case (i_cmd.op)
            OP_POP_START: raddr = AW'(sel_cnt - CW'(1));
            OP_POP_CHK:   raddr = c1[AW-1:0];
            OP_POP_RC1:   raddr = c2[AW-1:0];
            OP_PUSH_CHK:  raddr = parent;
            OP_POP_CMP: begin
                we    = sink;
                wdata = chosen;
            end
            OP_POP_END:   we = (r_n != '0);
            OP_PUSH_CMP: begin
                we    = rise;
                wdata = rdata;
            end
            OP_PUSH_END:  we = 1'b1;
            default: ;
        endcase
    end

    rmth_ram #(.WIDTH(SAMPLE_W), .DEPTH(HEAP_DEPTH)) u_lower (
        .i_clk   (i_clk),
        .i_we    (we && r_sel),
        .i_waddr (r_idx),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (l_rdata)
    );

    rmth_ram #(.WIDTH(SAMPLE_W), .DEPTH(HEAP_DEPTH)) u_upper (
        .i_clk   (i_clk),
        .i_we    (we && !r_sel),
        .i_waddr (r_idx),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (u_rdata)
    );

    assign cnt_sum = {1'b0, r_lcnt} + {1'b0, r_ucnt};

    always_comb begin
        if (r_lcnt == '0) begin
            median = '0;
        end else if (r_ucnt == '0 || r_lcnt > r_ucnt) begin
            median = {r_ltop, 1'b0};
        end else begin
            median = {r_ltop[SAMPLE_W-1], r_ltop} + {r_utop[SAMPLE_W-1], r_utop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcnt      <= '0;
            r_ucnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (i_cmd.op)
                OP_LOAD: r_sample <= i_sample;
                OP_POP_START: begin
                    r_sel <= i_cmd.sel_lower;
                    r_idx <= '0;
                    r_k   <= i_cmd.sel_lower ? r_ltop : r_utop;
                    r_n   <= sel_cnt - CW'(1);
                    if (i_cmd.sel_lower) begin
                        r_lcnt <= r_lcnt - CW'(1);
                    end else begin
                        r_ucnt <= r_ucnt - CW'(1);
                    end
                end
                OP_POP_LAST: r_val <= rdata;
                OP_POP_RC1:  r_a   <= rdata;
                OP_POP_CMP: begin
                    if (sink) begin
                        r_idx <= cidx;
                    end
                end
                OP_PUSH_START: begin
                    r_sel <= i_cmd.sel_lower;
                    r_idx <= AW'(sel_cnt);
                    r_val <= i_cmd.push_k ? r_k : r_sample;
                    if (i_cmd.sel_lower) begin
                        r_lcnt <= r_lcnt + CW'(1);
                    end else begin
                        r_ucnt <= r_ucnt + CW'(1);
                    end
                end
                OP_PUSH_CMP: begin
                    if (rise) begin
                        r_idx <= parent;
                    end
                end
                default: ;
            endcase

            // keep a copy of each root so the tops are always at hand
            if (we && r_idx == '0) begin
                if (r_sel) begin
                    r_ltop <= wdata;
                end else begin
                    r_utop <= wdata;
                end
            end

            if (i_cmd.op == OP_OUT) begin
                r_out_valid <= 1'b1;
                r_med       <= median;
                r_scnt      <= SCNT_W'(cnt_sum);
                r_drop      <= i_cmd.drop;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.l_empty      = (r_lcnt == '0);
    assign o_stat.u_empty      = (r_ucnt == '0);
    assign o_stat.full         = (r_lcnt == CW'(HEAP_DEPTH)) && (r_ucnt == CW'(HEAP_DEPTH));
    assign o_stat.v_lt_ltop    = (r_sample < r_ltop);
    assign o_stat.v_gt_utop    = (r_sample > r_utop);
    assign o_stat.cnt_eq       = (r_lcnt == r_ucnt);
    assign o_stat.push_at_root = (r_idx == '0);
    assign o_stat.push_rise    = rise;
    assign o_stat.pop_leaf     = (c1 >= nx);
    assign o_stat.pop_sink     = sink;
    assign o_stat.out_free     = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_median_x2    = r_med;
    assign o_sample_count = r_scnt;
    assign o_dropped      = r_drop;

endmodule

@@ design/rmth_ctrl.sv @@
module rmth_ctrl import rmth_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_POP_START,
        S_POP_LAST,
        S_POP_CHK,
        S_POP_RC1,
        S_POP_CMP,
        S_POP_END,
        S_PUSH_START,
        S_PUSH_CHK,
        S_PUSH_CMP,
        S_PUSH_END,
        S_FIN
    } t_state;

    t_state r_state;
    logic   r_mv_lower, r_push_lower, r_phase, r_drop;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd           = '0;
        o_cmd.op        = OP_NONE;
        o_cmd.drop      = r_drop;
        // phase 0 pushes the moved top into the other heap
        o_cmd.sel_lower = r_phase ? r_push_lower : !r_mv_lower;
        o_cmd.push_k    = !r_phase;
        case (r_state)
            S_IDLE:       o_cmd.op = i_in_valid ? OP_LOAD : OP_NONE;
            S_POP_START: begin
                o_cmd.op        = OP_POP_START;
                o_cmd.sel_lower = r_mv_lower;
            end
            S_POP_LAST:   o_cmd.op = OP_POP_LAST;
            S_POP_CHK:    o_cmd.op = OP_POP_CHK;
            S_POP_RC1:    o_cmd.op = OP_POP_RC1;
            S_POP_CMP:    o_cmd.op = OP_POP_CMP;
            S_POP_END:    o_cmd.op = OP_POP_END;
            S_PUSH_START: o_cmd.op = OP_PUSH_START;
            S_PUSH_CHK:   o_cmd.op = OP_PUSH_CHK;
            S_PUSH_CMP:   o_cmd.op = OP_PUSH_CMP;
            S_PUSH_END:   o_cmd.op = OP_PUSH_END;
            S_FIN:        o_cmd.op = i_stat.out_free ? OP_OUT : OP_NONE;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_mv_lower   <= 1'b0;
            r_push_lower <= 1'b0;
            r_phase      <= 1'b0;
            r_drop       <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_drop <= i_stat.full;
                    if (i_stat.l_empty) begin
                        r_push_lower <= 1'b1;
                    end else if (i_stat.u_empty) begin
                        r_mv_lower   <= 1'b1;
                        r_push_lower <= i_stat.v_lt_ltop;
                    end else if (!i_stat.v_lt_ltop && !i_stat.v_gt_utop) begin
                        r_push_lower <= i_stat.cnt_eq;
                    end else if (i_stat.v_gt_utop) begin
                        r_mv_lower   <= 1'b0;
                        r_push_lower <= 1'b0;
                    end else begin
                        r_mv_lower   <= 1'b1;
                        r_push_lower <= 1'b1;
                    end
                    r_state <= S_PUSH_START;
                    r_phase <= 1'b1;
                    if (i_stat.full) begin
                        r_state <= S_FIN;
                    end else if (i_stat.l_empty) begin
                        r_state <= S_PUSH_START;
                    end else if (i_stat.u_empty) begin
                        if (i_stat.v_lt_ltop) begin
                            r_state <= S_POP_START;
                            r_phase <= 1'b0;
                        end
                    end else if (!i_stat.v_lt_ltop && !i_stat.v_gt_utop) begin
                        r_state <= S_PUSH_START;
                    end else if (i_stat.v_gt_utop) begin
                        if (i_stat.cnt_eq) begin
                            r_state <= S_POP_START;
                            r_phase <= 1'b0;
                        end
                    end else if (!i_stat.cnt_eq) begin
                        r_state <= S_POP_START;
                        r_phase <= 1'b0;
                    end
                end
                S_POP_START: r_state <= S_POP_LAST;
                S_POP_LAST:  r_state <= S_POP_CHK;
                S_POP_CHK:   r_state <= i_stat.pop_leaf ? S_POP_END : S_POP_RC1;
                S_POP_RC1:   r_state <= S_POP_CMP;
                S_POP_CMP:   r_state <= i_stat.pop_sink ? S_POP_CHK : S_POP_END;
                S_POP_END:   r_state <= S_PUSH_START;
                S_PUSH_START: r_state <= S_PUSH_CHK;
                S_PUSH_CHK:  r_state <= i_stat.push_at_root ? S_PUSH_END : S_PUSH_CMP;
                S_PUSH_CMP:  r_state <= i_stat.push_rise ? S_PUSH_CHK : S_PUSH_END;
                S_PUSH_END: begin
                    if (!r_phase) begin
                        r_phase <= 1'b1;
                        r_state <= S_PUSH_START;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (i_stat.out_free) begin
                        r_drop  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ design/running_median_two_heaps_core.sv @@
// one word at a time: a new word is taken only once the previous one is done;
// each word takes at most one pop from one heap and up to two pushes
// the sift loops run over the single read port of each heap memory
// result is registered once the output is free; input is taken again in the cycle it appears
// synchronous active-low reset empties both heaps and clears the output valid
module running_median_two_heaps_core import rmth_pkg::*; #(
    parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [MED_W-1:0]    o_median_x2,
    output logic [SCNT_W-1:0]          o_sample_count,
    output logic                       o_dropped
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    rmth_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    rmth_datapath #(.HEAP_DEPTH(HEAP_DEPTH)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_sample       (i_sample),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_median_x2    (o_median_x2),
        .o_sample_count (o_sample_count),
        .o_dropped      (o_dropped)
    );

endmodule
